>>> sv/grq_pkg.sv
package grq_pkg;

    localparam int VERTEX_W = 6;

    localparam logic FUNC_ADD_EDGE = 1'b0;
    localparam logic FUNC_QUERY    = 1'b1;

    typedef struct packed {
        logic                func;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
    } req_t;

    typedef struct packed {
        logic reachable;
    } rsp_t;

endpackage

>>> sv/grq_req_if.sv
interface grq_req_if
    import grq_pkg::*;
();
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/grq_rsp_if.sv
interface grq_rsp_if
    import grq_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/grq_ram.sv
module grq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/graph_reachability_query_top.sv
// Channel | Direction | Payload                         | Transaction
// req     | in        | func, vertex_a, vertex_b        | one edge add or one query
// rsp     | out       | reachable                       | one answer per query
//
// An edge add is a read-modify-write of each row through the one write port and registered
// read port of the adjacency RAM; a self-loop writes one row, an add out of range is dropped.
// A query reads the row of one pending vertex at a time and marks its fresh neighbours until
// the target turns up or none is left; a self-query or one out of range is answered directly.
// Reset clears the row-valid bits at once; an unwritten row reads as empty. No clearing pass.
// req is ready only when idle; an answer waits in the rsp register while edge adds proceed.
module graph_reachability_query_top
    import grq_pkg::*;
#(
    parameter int VERTICES = 64
)(
    input  logic            clk,
    input  logic            rst_n,
    grq_req_if.sink         req,
    grq_rsp_if.source       rsp
);

    localparam int NV = (VERTICES < (1 << VERTEX_W)) ? VERTICES : (1 << VERTEX_W);
    localparam int IW = $clog2(NV);
    localparam logic [VERTEX_W:0] VLIM = (VERTEX_W + 1)'(NV);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE_A,
        S_EDGE_B,
        S_ISSUE,
        S_EXPAND,
        S_RESULT
    } state_t;

    state_t          state_reg;
    logic [IW-1:0]   a_reg;
    logic [IW-1:0]   b_reg;
    logic [NV-1:0]   visited_reg;
    logic [NV-1:0]   pending_reg;
    logic [NV-1:0]   row_valid_reg;
    logic            row_ok_reg;
    logic            result_reg;
    logic            rsp_valid_reg;
    logic            rsp_data_reg;

    logic            in_range;
    logic [IW-1:0]   a_in;
    logic [IW-1:0]   b_in;
    logic [NV-1:0]   pend_low;
    logic [IW-1:0]   pick_idx;
    logic [NV-1:0]   row_data;
    logic [NV-1:0]   fresh;
    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    logic [NV-1:0]   ram_wdata;
    logic [IW-1:0]   ram_raddr;
    logic [NV-1:0]   ram_rdata;

    grq_ram #(
        .WIDTH (NV),
        .DEPTH (NV)
    ) u_adj_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign a_in     = req.payload.vertex_a[IW-1:0];
    assign b_in     = req.payload.vertex_b[IW-1:0];
    assign in_range = ({1'b0, req.payload.vertex_a} < VLIM)
                   && ({1'b0, req.payload.vertex_b} < VLIM);

    assign pend_low = pending_reg & (~pending_reg + NV'(1));
    assign row_data = row_ok_reg ? ram_rdata : '0;
    assign fresh    = row_data & ~visited_reg;

    always_comb
    begin
        pick_idx = '0;
        for (int i = 0; i < NV; i++)
        begin
            if (pend_low[i])
            begin
                pick_idx = pick_idx | IW'(i);
            end
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = a_reg;
        ram_wdata = row_data | (NV'(1) << b_reg);
        ram_raddr = a_in;
        case (state_reg)
            S_EDGE_A:
            begin
                ram_we    = 1'b1;
                ram_raddr = b_reg;
            end
            S_EDGE_B:
            begin
                ram_we    = 1'b1;
                ram_waddr = b_reg;
                ram_wdata = row_data | (NV'(1) << a_reg);
            end
            S_ISSUE:
            begin
                ram_raddr = pick_idx;
            end
            default:
            begin
                ram_raddr = a_in;
            end
        endcase
    end

    assign req.ready             = (state_reg == S_IDLE);
    assign rsp.valid             = rsp_valid_reg;
    assign rsp.payload.reachable = rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            a_reg         <= '0;
            b_reg         <= '0;
            visited_reg   <= '0;
            pending_reg   <= '0;
            row_valid_reg <= '0;
            row_ok_reg    <= 1'b0;
            result_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= 1'b0;
        end
        else
        begin
            row_ok_reg <= row_valid_reg[ram_raddr];
            if (ram_we)
            begin
                row_valid_reg[ram_waddr] <= 1'b1;
            end
            if ((state_reg == S_RESULT) && (!rsp_valid_reg || rsp.ready))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        a_reg <= a_in;
                        b_reg <= b_in;
                        if (req.payload.func == FUNC_ADD_EDGE)
                        begin
                            if (in_range)
                            begin
                                state_reg <= S_EDGE_A;
                            end
                        end
                        else if (req.payload.vertex_a == req.payload.vertex_b)
                        begin
                            result_reg <= 1'b1;
                            state_reg  <= S_RESULT;
                        end
                        else if (!in_range)
                        begin
                            visited_reg <= '0;
                            result_reg  <= 1'b0;
                            state_reg   <= S_RESULT;
                        end
                        else
                        begin
                            visited_reg <= NV'(1) << a_in;
                            pending_reg <= NV'(1) << a_in;
                            state_reg   <= S_ISSUE;
                        end
                    end
                end
                S_EDGE_A:
                begin
                    state_reg <= (a_reg == b_reg) ? S_IDLE : S_EDGE_B;
                end
                S_EDGE_B:
                begin
                    state_reg <= S_IDLE;
                end
                S_ISSUE:
                begin
                    if (pending_reg == '0)
                    begin
                        result_reg <= 1'b0;
                        state_reg  <= S_RESULT;
                    end
                    else
                    begin
                        pending_reg <= pending_reg & ~pend_low;
                        state_reg   <= S_EXPAND;
                    end
                end
                S_EXPAND:
                begin
                    if (fresh[b_reg])
                    begin
                        result_reg <= 1'b1;
                        state_reg  <= S_RESULT;
                    end
                    else
                    begin
                        visited_reg <= visited_reg | fresh;
                        pending_reg <= pending_reg | fresh;
                        state_reg   <= S_ISSUE;
                    end
                end
                S_RESULT:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_data_reg  <= result_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
